// ===== sv/ffa_pkg.sv =====
// shared types and constants for the first-fit arena slot allocator
// no dependencies; imported by every module of the block
package ffa_pkg;

	localparam int MAX_SLOTS   = 16;
	localparam int ALIGN_BYTES = 64;   // power of two
	localparam int IDX_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_SLOTS + 1);

	localparam logic [32:0] ALIGN_LOW  = 33'(ALIGN_BYTES - 1);
	localparam logic [16:0] NEVER_FREE = 17'h1FFFF;

	localparam logic [1:0] STAT_PLACED   = 2'd0;
	localparam logic [1:0] STAT_SKIPPED  = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [16:0] free_from;
		logic [31:0] length;
		logic [31:0] base;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		slot_t            data;
	} slot_wr_t;

endpackage

// ===== sv/first_fit_arena_slot_allocator_core.sv =====
// top level of the first-fit arena slot allocator: sequencer, output register
// depends on ffa_pkg, ffa_slot_ram and ffa_fit_cmp
//
// One request word in, one result word out. A request is taken when the
// sequencer is idle; its size is rounded up to the alignment, then the slot
// table is scanned one slot per cycle through the single read port of the
// slot memory and the shared fit compare, stopping at the first fit. A
// finish step then appends a slot or reuses the fitting one if the request
// can be placed, and loads the result register once the output is free.
// The scan is skipped for an empty table, a zero size or a rounding overflow.
// The result register holds until taken while the next request is accepted.
module first_fit_arena_slot_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // def_index, last_use_index, keep_to_end, request_bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // buffer_offset, reused_slot, arena_total
	output logic [1:0]  m_axis_tuser   // status
);
	import ffa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] slots_used_q;
	logic [31:0]      arena_top_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      def_q;
	logic [15:0]      last_q;
	logic             keep_q;
	logic [31:0]      need_q;
	logic [1:0]       pre_stat_q;
	logic             found_q;
	logic [31:0]      base_q;
	logic [31:0]      len_q;

	logic             out_valid_q;
	logic [31:0]      out_offset_q;
	logic             out_reused_q;
	logic [31:0]      out_total_q;
	logic [1:0]       out_status_q;

	logic [15:0]      in_def;
	logic [15:0]      in_last;
	logic             in_keep;
	logic [31:0]      in_bytes;
	logic [32:0]      in_need;
	logic             accept;
	logic             fin_go;
	logic [IDX_W-1:0] rd_addr;
	slot_t            rd_slot;
	slot_wr_t         wr;
	logic             fit;
	logic             scan_last;
	logic [32:0]      top_sum;
	logic [16:0]      free_val;

	assign in_def   = s_axis_tdata[15:0];
	assign in_last  = s_axis_tdata[31:16];
	assign in_keep  = s_axis_tdata[32];
	assign in_bytes = s_axis_tdata[64:33];
	assign in_need  = ({1'b0, in_bytes} + ALIGN_LOW) & ~ALIGN_LOW;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
	assign scan_last     = ({1'b0, idx_q} + 1'b1) == (IDX_W + 1)'(slots_used_q);
	assign top_sum       = {1'b0, arena_top_q} + {1'b0, need_q};
	assign free_val      = keep_q ? NEVER_FREE : ({1'b0, last_q} + 17'd1);

	always_comb begin
		rd_addr = '0;
		if (state_q == ST_SCAN) begin
			rd_addr = idx_q + 1'b1;
		end
	end

	ffa_slot_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	ffa_fit_cmp u_fit (
		.slot      (rd_slot),
		.def_index (def_q),
		.need      (need_q),
		.fit       (fit)
	);

	always_comb begin
		wr = '0;
		if (fin_go && pre_stat_q == STAT_PLACED) begin
			if (found_q) begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = '{free_from: free_val, length: len_q, base: base_q};
			end else if (slots_used_q != CNT_W'(MAX_SLOTS) && !top_sum[32]) begin
				wr.en   = 1'b1;
				wr.addr = slots_used_q[IDX_W-1:0];
				wr.data = '{free_from: free_val, length: need_q, base: arena_top_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slots_used_q <= '0;
			arena_top_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_bytes == '0 || in_need[32] || slots_used_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (fit || scan_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (wr.en && !found_q) begin
							slots_used_q <= slots_used_q + 1'b1;
							arena_top_q  <= top_sum[31:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			def_q   <= in_def;
			last_q  <= in_last;
			keep_q  <= in_keep;
			need_q  <= in_need[31:0];
			idx_q   <= '0;
			found_q <= 1'b0;
			priority if (in_bytes == '0) begin
				pre_stat_q <= STAT_SKIPPED;
			end else if (in_need[32]) begin
				pre_stat_q <= STAT_OVERFLOW;
			end else begin
				pre_stat_q <= STAT_PLACED;
			end
		end
		if (state_q == ST_SCAN) begin
			if (fit) begin
				found_q <= 1'b1;
				base_q  <= rd_slot.base;
				len_q   <= rd_slot.length;
			end else if (!scan_last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (fin_go) begin
			priority if (pre_stat_q != STAT_PLACED) begin
				out_status_q <= pre_stat_q;
				out_offset_q <= '0;
				out_reused_q <= 1'b0;
				out_total_q  <= arena_top_q;
			end else if (found_q) begin
				out_status_q <= STAT_PLACED;
				out_offset_q <= base_q;
				out_reused_q <= 1'b1;
				out_total_q  <= arena_top_q;
			end else if (slots_used_q == CNT_W'(MAX_SLOTS)) begin
				out_status_q <= STAT_FULL;
				out_offset_q <= '0;
				out_reused_q <= 1'b0;
				out_total_q  <= arena_top_q;
			end else if (top_sum[32]) begin
				out_status_q <= STAT_OVERFLOW;
				out_offset_q <= '0;
				out_reused_q <= 1'b0;
				out_total_q  <= arena_top_q;
			end else begin
				out_status_q <= STAT_PLACED;
				out_offset_q <= arena_top_q;
				out_reused_q <= 1'b0;
				out_total_q  <= top_sum[31:0];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_total_q, out_reused_q, out_offset_q};
	assign m_axis_tuser  = out_status_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= CNT_W'(MAX_SLOTS))
		else $error("slot count beyond table size");

	a_top_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> arena_top_q >= $past(arena_top_q))
		else $error("arena top went down");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_PLACED |->
		m_axis_tdata[31:0] == '0 && !m_axis_tdata[32])
		else $error("offset or reuse set on a non-placed result");

	a_wr_fin: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == ST_FIN && pre_stat_q == STAT_PLACED)
		else $error("slot write outside the finish step");

endmodule

// ===== sv/ffa_slot_ram.sv =====
// slot table storage: one write port, one read port with registered data
// depends on ffa_pkg
module ffa_slot_ram (
	input  logic                    clk,
	input  ffa_pkg::slot_wr_t       wr,
	input  logic [ffa_pkg::IDX_W-1:0] rd_addr,
	output ffa_pkg::slot_t          rd_data
);
	import ffa_pkg::*;

	slot_t mem_q [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/ffa_fit_cmp.sv =====
// shared fit check: slot free at the defining node and large enough
// depends on ffa_pkg
module ffa_fit_cmp (
	input  ffa_pkg::slot_t slot,
	input  logic [15:0]    def_index,
	input  logic [31:0]    need,
	output logic           fit
);
	import ffa_pkg::*;

	assign fit = (slot.free_from <= {1'b0, def_index}) && (slot.length >= need);

endmodule

// ===== verif/first_fit_arena_slot_allocator_core_tb.sv =====
// testbench for first_fit_arena_slot_allocator_core: directed and random buffer requests,
// results checked field by field against a behavioral first-fit slot table
// depends on ffa_pkg and the rtl of the block only
`timescale 1ns / 1ps

module first_fit_arena_slot_allocator_core_tb;
	import ffa_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 6;
	localparam int RANDOM_REQUESTS = 1400;
	localparam int HOLD_CYCLES     = 600;
	localparam int HOLD_AFTER      = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int RANDOM_PINS     = 5;

	typedef struct {
		logic [15:0] def_index;
		logic [15:0] last_use_index;
		logic        keep_to_end;
		logic [31:0] request_bytes;
	} alloc_request_t;

	typedef struct {
		logic [31:0] buffer_offset;
		logic        reused_slot;
		logic [31:0] arena_total;
		logic [1:0]  status;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;  // def_index, last_use_index, keep_to_end, request_bytes
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;       // buffer_offset, reused_slot, arena_total
	logic [1:0]  m_axis_tuser;       // status

	first_fit_arena_slot_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// shadow slot table
	logic [31:0]    shadow_base [MAX_SLOTS];
	logic [31:0]    shadow_length [MAX_SLOTS];
	logic [16:0]    shadow_free_from [MAX_SLOTS];
	int unsigned    shadow_used = 0;
	logic [31:0]    shadow_top = '0;

	alloc_request_t pending_requests [$];
	alloc_result_t  expected_placements [$];
	alloc_request_t offered_request;

	int total_requests = 0;
	int requests_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int status_count [4] = '{default: 0};
	int reuse_count = 0;
	int idle_cycles = 0;

	function automatic alloc_result_t place_request(alloc_request_t rq);
		alloc_result_t res;
		logic [32:0]   need;
		logic [32:0]   new_top;
		int            pick;
		bit            found;
		res.buffer_offset = '0;
		res.reused_slot = 1'b0;
		res.status = STAT_PLACED;
		pick = 0;
		found = 1'b0;
		if (rq.request_bytes == 32'd0) begin
			res.status = STAT_SKIPPED;
		end else begin
			need = ((33'(rq.request_bytes) + 33'(ALIGN_BYTES - 1)) / 33'(ALIGN_BYTES))
				* 33'(ALIGN_BYTES);
			if (need[32]) begin
				res.status = STAT_OVERFLOW;
			end else begin
				for (int i = 0; i < int'(shadow_used); i++) begin
					if (!found && shadow_free_from[i] <= {1'b0, rq.def_index}
							&& {1'b0, shadow_length[i]} >= need) begin
						found = 1'b1;
						pick = i;
					end
				end
				new_top = 33'(shadow_top) + need;
				if (!found && shadow_used >= MAX_SLOTS) begin
					res.status = STAT_FULL;
				end else if (!found && new_top[32]) begin
					res.status = STAT_OVERFLOW;
				end else begin
					if (!found) begin
						pick = shadow_used;
						shadow_base[pick] = shadow_top;
						shadow_length[pick] = need[31:0];
						shadow_used++;
						shadow_top = new_top[31:0];
					end
					shadow_free_from[pick] = rq.keep_to_end ? NEVER_FREE
						: 17'(rq.last_use_index) + 17'd1;
					res.buffer_offset = shadow_base[pick];
					res.reused_slot = found;
				end
			end
		end
		res.arena_total = shadow_top;
		status_count[res.status]++;
		if (res.reused_slot)
			reuse_count++;
		return res;
	endfunction

	function automatic void queue_request(logic [15:0] def_index, logic [15:0] last_use_index,
			logic keep_to_end, logic [31:0] request_bytes);
		alloc_request_t rq;
		rq.def_index = def_index;
		rq.last_use_index = last_use_index;
		rq.keep_to_end = keep_to_end;
		rq.request_bytes = request_bytes;
		pending_requests = {pending_requests, rq};
	endfunction

	task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", field_name, want, got);
			mismatches++;
		end
	endtask

	// sender: bursts of words with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_placements = {expected_placements, place_request(offered_request)};
				requests_taken++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					offered_request = pending_requests.pop_front();
					s_axis_tdata <= {7'd0, offered_request.request_bytes,
						offered_request.keep_to_end, offered_request.last_use_index,
						offered_request.def_index};
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern in runs, plus one long hold-off
	int ready_run = 0;
	int ready_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (ready_run == 0) begin
					ready_run = $urandom_range(1, 60);
					ready_mode = $urandom_range(0, 2);
				end
				ready_run--;
				unique case (ready_mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_placements.size() == 0) begin
				$error("unexpected result word: tdata 0x%018h status %0d",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = expected_placements.pop_front();
				check_field("buffer_offset", want.buffer_offset, m_axis_tdata[31:0]);
				check_field("reused_slot", 32'(want.reused_slot), 32'(m_axis_tdata[32]));
				check_field("arena_total", want.arena_total, m_axis_tdata[64:33]);
				check_field("status", 32'(want.status), 32'(m_axis_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int          node;
		int          pins_left;
		int          pick_kind;
		logic [15:0] def_index;
		logic [15:0] last_use_index;
		logic        keep_to_end;
		logic [31:0] request_bytes;

		// directed: zero size, rounding overflow, append, arena overflow, reuse, pinning
		queue_request(16'd0, 16'd0, 1'b0, 32'd0);
		queue_request(16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		queue_request(16'd5, 16'd9, 1'b0, 32'hFFFF_FFC1);
		queue_request(16'd0, 16'd2, 1'b0, 32'd1);
		queue_request(16'd1, 16'd5, 1'b0, 32'hFFFF_FFC0);
		queue_request(16'd1, 16'd3, 1'b0, 32'd64);
		queue_request(16'd3, 16'd6, 1'b0, 32'd65);
		queue_request(16'd3, 16'd4, 1'b0, 32'd63);
		queue_request(16'd4, 16'd9, 1'b1, 32'd100);
		queue_request(16'd7, 16'd8, 1'b0, 32'd128);
		queue_request(16'hFFFF, 16'hFFFF, 1'b0, 32'h40);
		queue_request(16'h20, 16'h10, 1'b0, 32'd32);
		queue_request(16'd10, 16'd12, 1'b0, 32'h1000);
		queue_request(16'd20, 16'd0, 1'b0, 32'hFFFF_FF80);
		queue_request(16'd0, 16'd0, 1'b1, 32'd0);
		queue_request(16'd9, 16'hFFFF, 1'b1, 32'd1);
		queue_request(16'd14, 16'd14, 1'b0, 32'h7FFF);
		queue_request(16'd15, 16'd30, 1'b0, 32'h0001_0000);

		// random: a node schedule that moves forward, with some noise
		node = 16'h40;
		pins_left = RANDOM_PINS;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			node += $urandom_range(0, 2);
			def_index = 16'(node);
			last_use_index = 16'(node + $urandom_range(0, 24));
			keep_to_end = 1'b0;
			pick_kind = $urandom_range(0, 99);
			if (pick_kind < 70) begin
				request_bytes = $urandom_range(1, 2048);
			end else if (pick_kind < 80) begin
				request_bytes = $urandom_range(2049, 70000);
			end else if (pick_kind < 85) begin
				request_bytes = 32'd0;
				keep_to_end = 1'($urandom_range(0, 1));
			end else if (pick_kind < 90) begin
				request_bytes = $urandom_range(32'hFFFF_FF81, 32'hFFFF_FFFF);
				keep_to_end = 1'($urandom_range(0, 1));
			end else begin
				def_index = 16'($urandom_range(0, 16'hFFFF));
				last_use_index = 16'($urandom_range(0, node));
				request_bytes = $urandom_range(1, 4096);
			end
			if (request_bytes != 0 && request_bytes < 32'h0010_0000 && pins_left > 0
					&& $urandom_range(0, 19) == 0) begin
				keep_to_end = 1'b1;
				pins_left--;
			end
			queue_request(def_index, last_use_index, keep_to_end, request_bytes);
		end
		total_requests = pending_requests.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_taken < total_requests || expected_placements.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests %0d: placed %0d (reused %0d), skipped %0d, table full %0d, overflow %0d",
			total_requests, status_count[STAT_PLACED], reuse_count, status_count[STAT_SKIPPED],
			status_count[STAT_FULL], status_count[STAT_OVERFLOW]);
		$display("slots in use %0d, arena top 0x%08h, mismatches %0d",
			shadow_used, shadow_top, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
